// ===== design/one_bit_mask_or_merge_top_defines.svh =====
// assertion macros used by the checker file omb_checker.sv
`ifndef ONE_BIT_MASK_OR_MERGE_TOP_DEFINES_SVH
`define ONE_BIT_MASK_OR_MERGE_TOP_DEFINES_SVH

// property checked on every rising edge of clk_i, muted while rst_ni is low
`define OMB_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define OMB_ASSERT_NEXT(lbl, pre, post, msg) \
  `OMB_ASSERT_CLK(lbl, (pre) |=> (post), msg)

`endif

// ===== design/omb_pkg.sv =====
`timescale 1ns / 1ps

package omb_pkg;

  // fixed field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 12;
  localparam int unsigned DimW  = 13;
  localparam int unsigned OffW  = 3;
  localparam int unsigned ColW  = DimW - OffW;
  localparam int unsigned RowW  = 12;
  localparam int unsigned IdxW  = 3;

  // largest usable width or height, larger register values saturate to it
  localparam logic [DimW-1:0] MaxDim = DimW'(4096);

  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = QPtrW + 1;

  // configuration register indexes
  typedef enum logic [IdxW-1:0] {
    RegOverlayX        = 3'd0,
    RegOverlayY        = 3'd1,
    RegOverlayWidth    = 3'd2,
    RegOverlayHeight   = 3'd3,
    RegCompositeWidth  = 3'd4,
    RegCompositeHeight = 3'd5
  } omb_reg_e;

  // classified item handed from front to back
  typedef struct packed {
    logic [ByteW-1:0] dest;
    logic [ByteW-1:0] ov;
    logic [OffW-1:0]  off;
    logic             empty;
    logic             last_row;
    logic             last_frame;
  } omb_item_t;

  function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] v);
    return (v > MaxDim) ? MaxDim : v;
  endfunction

endpackage

// ===== design/omb_if.sv =====
`timescale 1ns / 1ps

// input request: overlay and destination bytes
interface omb_in_if;
  logic                        valid;
  logic                        ready;
  logic [omb_pkg::ByteW-1:0]   overlay_byte;
  logic [omb_pkg::ByteW-1:0]   dest_byte;

  modport source (output valid, output overlay_byte, output dest_byte, input ready);
  modport sink   (input valid, input overlay_byte, input dest_byte, output ready);
endinterface

// output request: merged byte with row and frame marks
interface omb_out_if;
  logic                        valid;
  logic                        ready;
  logic [omb_pkg::ByteW-1:0]   merged_byte;
  logic                        last_in_row;
  logic                        last_in_frame;

  modport source (output valid, output merged_byte, output last_in_row,
                  output last_in_frame, input ready);
  modport sink   (input valid, input merged_byte, input last_in_row,
                  input last_in_frame, output ready);
endinterface

// configuration write request
interface omb_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [omb_pkg::IdxW-1:0]    index;
  logic [omb_pkg::DimW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/omb_front.sv =====
`timescale 1ns / 1ps

module omb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  omb_cfg_if.sink            cfg_i,
  omb_in_if.sink             in_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output omb_pkg::omb_item_t push_item_o
);
  import omb_pkg::*;

  logic [PosW-1:0] ovl_x_q, ovl_y_q;
  logic [DimW-1:0] ovl_w_q, ovl_h_q, comp_w_q, comp_h_q;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic [DimW-1:0] cw, ch, ow, oh, avail_w, avail_h, w, h;
  logic [DimW-1:0] span_sum, obytes_sum;
  logic [ColW-1:0] span, obytes;
  logic [OffW-1:0] off, tail;
  logic [ByteW-1:0] ov;
  logic             empty, last_row, last_frame, accept;

  // configuration writes, always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovl_x_q  <= '0;
      ovl_y_q  <= '0;
      ovl_w_q  <= DimW'(1);
      ovl_h_q  <= DimW'(1);
      comp_w_q <= DimW'(1);
      comp_h_q <= DimW'(1);
    end else if (cfg_i.valid) begin
      case (omb_reg_e'(cfg_i.index))
        RegOverlayX:        ovl_x_q  <= cfg_i.data[PosW-1:0];
        RegOverlayY:        ovl_y_q  <= cfg_i.data[PosW-1:0];
        RegOverlayWidth:    ovl_w_q  <= cfg_i.data;
        RegOverlayHeight:   ovl_h_q  <= cfg_i.data;
        RegCompositeWidth:  comp_w_q <= cfg_i.data;
        RegCompositeHeight: comp_h_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // clip geometry
  always_comb begin
    cw      = sat_dim(comp_w_q);
    ch      = sat_dim(comp_h_q);
    ow      = sat_dim(ovl_w_q);
    oh      = sat_dim(ovl_h_q);
    empty   = ({1'b0, ovl_x_q} >= cw) || ({1'b0, ovl_y_q} >= ch) ||
              (ow == '0) || (oh == '0);
    avail_w = cw - {1'b0, ovl_x_q};
    avail_h = ch - {1'b0, ovl_y_q};
    w       = (ow < avail_w) ? ow : avail_w;
    h       = (oh < avail_h) ? oh : avail_h;
    off     = ovl_x_q[OffW-1:0];
    tail    = w[OffW-1:0];
    span_sum   = w + DimW'(off) + DimW'(7);
    obytes_sum = w + DimW'(7);
    span    = span_sum[DimW-1:OffW];
    obytes  = obytes_sum[DimW-1:OffW];
  end

  // overlay byte: zero past the overlay, partial last byte keeps its top bits
  always_comb begin
    ov = (col_q < obytes) ? in_i.overlay_byte : '0;
    if ((tail != '0) && (col_q == obytes - ColW'(1))) begin
      ov = ov & ~(8'hFF >> tail);
    end
    last_row   = ({1'b0, col_q} + (ColW+1)'(1)) >= {1'b0, span};
    last_frame = last_row && ((DimW'(row_q) + DimW'(1)) >= h);
  end

  // classified item
  assign accept       = in_i.valid && push_ready_i;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  always_comb begin
    push_item_o.dest       = in_i.dest_byte;
    push_item_o.ov         = ov;
    push_item_o.off        = off;
    push_item_o.empty      = empty;
    push_item_o.last_row   = empty || last_row;
    push_item_o.last_frame = empty || last_frame;
  end

  // span column and row position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept && !empty) begin
      if (last_row) begin
        col_d = '0;
        row_d = last_frame ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== design/omb_queue.sv =====
`timescale 1ns / 1ps

module omb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  omb_pkg::omb_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output omb_pkg::omb_item_t pop_item_o
);
  import omb_pkg::*;

  omb_item_t        entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  // pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== design/omb_back.sv =====
`timescale 1ns / 1ps

module omb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  omb_pkg::omb_item_t pop_item_i,
  omb_out_if.source          out_o
);
  import omb_pkg::*;

  logic [2*ByteW-1:0] shifted;
  logic [ByteW-1:0]   spill_q, spill_d, merged_q, merged_d;
  logic               valid_q, row_q, frame_q, take;

  // output register free or draining
  assign pop_ready_o = !valid_q || out_o.ready;
  assign take        = pop_valid_i && pop_ready_o;

  // shift overlay by the bit offset, low byte is the spill
  always_comb begin
    shifted = {pop_item_i.ov, {ByteW{1'b0}}} >> pop_item_i.off;
    if (pop_item_i.empty) begin
      merged_d = pop_item_i.dest;
      spill_d  = spill_q;
    end else begin
      merged_d = pop_item_i.dest | shifted[2*ByteW-1:ByteW] | spill_q;
      spill_d  = pop_item_i.last_row ? '0 : shifted[ByteW-1:0];
    end
  end

  // control and spill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      spill_q <= '0;
    end else begin
      if (take) begin
        valid_q <= 1'b1;
        spill_q <= spill_d;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      merged_q <= merged_d;
      row_q    <= pop_item_i.last_row;
      frame_q  <= pop_item_i.last_frame;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.merged_byte   = merged_q;
  assign out_o.last_in_row   = row_q;
  assign out_o.last_in_frame = frame_q;

endmodule

// ===== design/one_bit_mask_or_merge_top.sv =====
`timescale 1ns / 1ps

// One-bit-per-pixel OR merge of an overlay mask into a composite mask.
// Channels: in_i takes one request per composite byte of the touched span
// (overlay_byte and dest_byte), out_o gives one request per input with
// merged_byte, last_in_row and last_in_frame. cfg_i writes the six geometry
// registers (index 0..5: overlay x, y, width, height, composite width,
// height); it is always ready and must only be used while the block is idle.
// Path: an accepted input is written into the queue and then taken into the
// output register that drives out_o.valid; a stall on out_o can hold it in the queue.
// One byte per cycle while out_o keeps up, with a combinational span classifier
// in the front and the shift and OR into the output register in the back.
// A two-entry queue between front and back plus the output register holds
// up to three requests; in_i.ready drops once the queue is full, which in a
// full-rate stream comes one accepted request after out_o stalls.
// Reset: geometry returns to x = y = 0 and all sizes 1, span column, row and
// spill bits clear, and no result is pending.
module one_bit_mask_or_merge_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  omb_cfg_if.sink   cfg_i,
  omb_in_if.sink    in_i,
  omb_out_if.source out_o
);
  import omb_pkg::*;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  omb_item_t push_item, pop_item;

  // span tracking and overlay byte classification
  omb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // decoupling queue
  omb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // shift, spill carry and merge
  omb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

endmodule

// ===== design/omb_checker.sv =====
`timescale 1ns / 1ps
`include "one_bit_mask_or_merge_top_defines.svh"

module omb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic last_in_row_i,
  input logic last_in_frame_i
);

  logic [2:0] outstanding_q, outstanding_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // requests taken but not yet delivered
  always_comb begin
    outstanding_d = outstanding_q + 3'(in_acc) - 3'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_d;
    end
  end

  `OMB_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `OMB_ASSERT_CLK(a_frame_ends_row, out_valid_i |-> (!last_in_frame_i || last_in_row_i), "frame end off row end")
  `OMB_ASSERT_CLK(a_no_invented, out_valid_i |-> (outstanding_q != 3'd0), "result without request")
  `OMB_ASSERT_CLK(a_capacity, outstanding_q <= 3'd3, "more requests in flight than storage")

endmodule

bind one_bit_mask_or_merge_top omb_checker u_omb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .last_in_row_i   (out_o.last_in_row),
  .last_in_frame_i (out_o.last_in_frame)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import omb_pkg::*;

  localparam int unsigned IdlePct       = 31;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TargetBytes   = 1200;
  localparam int unsigned PhaseCap      = 160;
  localparam int unsigned DimCap        = 4096;

  typedef struct packed {
    logic [PosW-1:0] ox;
    logic [PosW-1:0] oy;
    logic [DimW-1:0] ow;
    logic [DimW-1:0] oh;
    logic [DimW-1:0] cw;
    logic [DimW-1:0] ch;
  } geom_t;

  typedef struct {
    bit          empty;
    int unsigned w;
    int unsigned h;
    int unsigned off;
    int unsigned span;
    int unsigned obytes;
  } clip_t;

  typedef struct packed {
    logic [ByteW-1:0] merged;
    logic             row_end;
    logic             frame_end;
  } merge_t;

  typedef struct packed {
    omb_reg_e        idx;
    logic [DimW-1:0] data;
  } reg_write_t;

  logic clk_i;
  logic rst_ni;

  omb_cfg_if cfg_if ();
  omb_in_if  in_if ();
  omb_out_if out_if ();

  one_bit_mask_or_merge_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // pending requests, filled on falling edges by the stimulus
  logic [2*ByteW-1:0] span_byte_q[$];
  reg_write_t         reg_write_q[$];

  // predictor copy of the geometry and the span walk
  geom_t            geo;
  logic [ColW-1:0]  col;
  logic [RowW-1:0]  row;
  logic [ByteW-1:0] spill;
  merge_t           merged_q[$];

  int unsigned n_queued, n_cfg_queued, n_phases;
  int unsigned n_sent, n_recv, n_cfg, n_frames, n_errors;
  int unsigned stall_cycles, hold_cnt;
  bit          calm;
  bit          hold_off;

  function automatic geom_t make_geom(input int unsigned ox, oy, ow, oh, cw, ch);
    return '{ox: PosW'(ox), oy: PosW'(oy), ow: DimW'(ow), oh: DimW'(oh),
             cw: DimW'(cw), ch: DimW'(ch)};
  endfunction

  function automatic int unsigned cap_dim(input logic [DimW-1:0] v);
    int unsigned u;
    u = v;
    return (u > DimCap) ? DimCap : u;
  endfunction

  // clipped overlay rectangle and the byte span it touches per row
  function automatic clip_t clip_region(input geom_t g);
    clip_t       c;
    int unsigned cw, ch, ow, oh;
    cw = cap_dim(g.cw);
    ch = cap_dim(g.ch);
    ow = cap_dim(g.ow);
    oh = cap_dim(g.oh);
    c = '{default: 0};
    c.empty = (g.ox >= cw) || (g.oy >= ch) || (ow == 0) || (oh == 0);
    if (!c.empty) begin
      c.w      = (ow < cw - g.ox) ? ow : cw - g.ox;
      c.h      = (oh < ch - g.oy) ? oh : ch - g.oy;
      c.off    = g.ox % 8;
      c.span   = (c.off + c.w + 7) / 8;
      c.obytes = (c.w + 7) / 8;
    end
    return c;
  endfunction

  // one merged byte from the current geometry, advancing column, row and carry
  function automatic merge_t merge_step(input logic [ByteW-1:0] ovb, dst);
    clip_t       c;
    merge_t      r;
    int unsigned ov, k;
    c = clip_region(geo);
    if (c.empty) return '{merged: dst, row_end: 1'b1, frame_end: 1'b1};
    k  = col;
    ov = (k < c.obytes) ? ovb : 0;
    if ((c.w % 8) != 0 && k == c.obytes - 1) ov &= 32'hFF << (8 - c.w % 8);
    r.merged    = ByteW'(dst | (ov >> c.off) | spill);
    spill       = (c.off != 0) ? ByteW'(ov << (8 - c.off)) : '0;
    r.row_end   = (k + 1 >= c.span);
    r.frame_end = r.row_end && (row + 1 >= c.h);
    if (r.row_end) begin
      col   = '0;
      spill = '0;
      row   = r.frame_end ? '0 : row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
    return r;
  endfunction

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    in_if.valid        = 1'b0;
    in_if.overlay_byte = '0;
    in_if.dest_byte    = '0;
    out_if.ready       = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  // byte request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.overlay_byte <= '0;
      in_if.dest_byte    <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (span_byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        in_if.valid <= 1'b1;
        {in_if.overlay_byte, in_if.dest_byte} <= span_byte_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // register write driver
  always @(posedge clk_i or negedge rst_ni) begin
    reg_write_t wr;
    if (!rst_ni) begin
      cfg_if.valid <= 1'b0;
      cfg_if.index <= '0;
      cfg_if.data  <= '0;
    end else if (!cfg_if.valid || cfg_if.ready) begin
      if (reg_write_q.size() != 0) begin
        wr = reg_write_q.pop_front();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= wr.idx;
        cfg_if.data  <= wr.data;
      end else begin
        cfg_if.valid <= 1'b0;
      end
    end
  end

  // result ready, with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_cnt     <= 0;
    end else if (hold_off && hold_cnt < HoldCycles) begin
      out_if.ready <= 1'b0;
      hold_cnt     <= hold_cnt + 1;
    end else begin
      out_if.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
      if (!hold_off) hold_cnt <= 0;
    end
  end

  // scoreboard: register writes, predictions and result checks
  always @(posedge clk_i or negedge rst_ni) begin
    merge_t got, want;
    if (!rst_ni) begin
      geo   = make_geom(0, 0, 1, 1, 1, 1);
      col   = '0;
      row   = '0;
      spill = '0;
      merged_q.delete();
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{merged: out_if.merged_byte, row_end: out_if.last_in_row,
                frame_end: out_if.last_in_frame};
        n_recv++;
        if (got.frame_end === 1'b1) n_frames++;
        if (merged_q.size() == 0) begin
          $error("result with no pending expectation: merged_byte %02h", got.merged);
          n_errors++;
        end else begin
          want = merged_q.pop_front();
          if (got.merged !== want.merged) begin
            $error("merged_byte: expected %02h, got %02h", want.merged, got.merged);
            n_errors++;
          end
          if (got.row_end !== want.row_end) begin
            $error("last_in_row: expected %0b, got %0b", want.row_end, got.row_end);
            n_errors++;
          end
          if (got.frame_end !== want.frame_end) begin
            $error("last_in_frame: expected %0b, got %0b", want.frame_end, got.frame_end);
            n_errors++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        n_cfg++;
        case (cfg_if.index)
          RegOverlayX:        geo.ox = cfg_if.data[PosW-1:0];
          RegOverlayY:        geo.oy = cfg_if.data[PosW-1:0];
          RegOverlayWidth:    geo.ow = cfg_if.data;
          RegOverlayHeight:   geo.oh = cfg_if.data;
          RegCompositeWidth:  geo.cw = cfg_if.data;
          RegCompositeHeight: geo.ch = cfg_if.data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        n_sent++;
        merged_q.push_back(merge_step(in_if.overlay_byte, in_if.dest_byte));
      end
    end
  end

  // watchdog on cycles with no request moving anywhere
  always @(posedge clk_i) begin
    if (!rst_ni || (cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready) ||
        (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic wait_idle();
    while (n_sent != n_queued || n_recv != n_queued || n_cfg != n_cfg_queued)
      @(negedge clk_i);
  endtask

  task automatic queue_byte(input logic [ByteW-1:0] ovb, dst);
    span_byte_q.push_back({ovb, dst});
    n_queued++;
  endtask

  // all six registers, written once the block has drained
  task automatic set_geometry(input geom_t g);
    wait_idle();
    repeat (3) @(negedge clk_i);
    reg_write_q.push_back('{RegOverlayX,        {1'b0, g.ox}});
    reg_write_q.push_back('{RegOverlayY,        {1'b0, g.oy}});
    reg_write_q.push_back('{RegOverlayWidth,    g.ow});
    reg_write_q.push_back('{RegOverlayHeight,   g.oh});
    reg_write_q.push_back('{RegCompositeWidth,  g.cw});
    reg_write_q.push_back('{RegCompositeHeight, g.ch});
    n_cfg_queued += 6;
    while (n_cfg != n_cfg_queued) @(negedge clk_i);
    n_phases++;
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return 8'hFF;
    if (p < 20) return 8'h00;
    return ByteW'($urandom_range(0, 255));
  endfunction

  // random geometry, mostly small, then a few frames of random bytes
  task automatic random_phase();
    geom_t       g;
    clip_t       c;
    int unsigned pick, fb, n;
    pick = $urandom_range(0, 99);
    g.cw = DimW'($urandom_range(1, 80));
    g.ch = DimW'($urandom_range(1, 6));
    g.ox = PosW'($urandom_range(0, g.cw + 2));
    g.oy = PosW'($urandom_range(0, g.ch));
    g.ow = DimW'($urandom_range(1, 72));
    g.oh = DimW'($urandom_range(1, 5));
    if (pick < 4) begin
      // zero-sized overlay
      if (pick[0]) g.ow = '0;
      else g.oh = '0;
    end else if (pick < 12) begin
      // far corner, sizes up to and past saturation
      g.cw = DimW'($urandom_range(4000, 8191));
      g.ch = DimW'($urandom_range(4090, 8191));
      g.ox = PosW'($urandom_range(3990, 4095));
      g.oy = PosW'($urandom_range(4085, 4095));
      g.ow = DimW'($urandom_range(1, 8191));
      g.oh = DimW'($urandom_range(1, 8191));
    end else if (pick < 15) begin
      // full-width rows, usually left unfinished
      g.cw = MaxDim;
      g.ox = PosW'($urandom_range(0, 7));
      g.ow = DimW'($urandom_range(4090, 8191));
    end
    set_geometry(g);
    c  = clip_region(g);
    fb = c.empty ? 1 : c.span * c.h;
    n  = fb * $urandom_range(1, 3);
    if ($urandom_range(0, 4) == 0) n += $urandom_range(1, fb);
    if (n > PhaseCap) n = PhaseCap;
    repeat (n) queue_byte(pick_byte(), pick_byte());
  endtask

  // stimulus
  initial begin
    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    // geometry straight out of reset
    queue_byte(8'hFF, 8'h00);
    queue_byte(8'h00, 8'hFF);

    // odd offset with a partial last overlay byte, two rows
    set_geometry(make_geom(3, 0, 10, 2, 16, 4));
    queue_byte(8'hFF, 8'h00);
    queue_byte(8'hFF, 8'h00);
    queue_byte(8'h00, 8'hFF);
    queue_byte(8'hA5, 8'h5A);

    // span one byte wider than the overlay, carry only in the last byte
    set_geometry(make_geom(6, 1, 8, 1, 24, 3));
    queue_byte(8'hFF, 8'h00);
    queue_byte(8'hFF, 8'h00);

    // empty clips: off to the right, zero width, zero height, below the bottom
    set_geometry(make_geom(20, 0, 8, 1, 16, 4));
    queue_byte(8'hFF, 8'h3C);
    queue_byte(8'h81, 8'h00);
    set_geometry(make_geom(0, 0, 0, 1, 16, 4));
    queue_byte(8'hFF, 8'h12);
    set_geometry(make_geom(0, 0, 8, 0, 16, 4));
    queue_byte(8'hFF, 8'h34);
    set_geometry(make_geom(0, 4, 8, 1, 16, 4));
    queue_byte(8'hFF, 8'h56);

    // oversized registers saturate, overlay at the far corner
    set_geometry(make_geom(4095, 4095, 8191, 8191, 8191, 8191));
    queue_byte(8'hFF, 8'h00);
    queue_byte(8'h7F, 8'hFE);

    // full-size frame left mid-row, then a geometry whose span is already passed
    set_geometry(make_geom(0, 0, 4096, 4096, 4096, 4096));
    queue_byte(8'hFF, 8'h00);
    queue_byte(8'h00, 8'hFF);
    queue_byte(8'h96, 8'h69);
    set_geometry(make_geom(0, 0, 8, 1, 8, 1));
    queue_byte(8'hF0, 8'h0F);
    queue_byte(8'h0F, 8'hF0);

    // long output hold-off while requests keep coming
    set_geometry(make_geom(0, 0, 64, 4, 64, 4));
    calm     = 1'b1;
    hold_off = 1'b1;
    repeat (64) queue_byte(pick_byte(), pick_byte());
    wait_idle();
    @(negedge clk_i);
    hold_off = 1'b0;
    calm     = 1'b0;

    // random geometries, with a stretch of phases run without idling
    while (n_queued < TargetBytes) begin
      calm = (n_phases >= 20 && n_phases < 32);
      random_phase();
    end
    calm = 1'b0;

    wait_idle();
    repeat (SettleCycles) @(negedge clk_i);
    if (merged_q.size() != 0) begin
      $error("%0d merged bytes never arrived", merged_q.size());
      n_errors++;
    end
    $display("merged %0d bytes under %0d register settings, %0d frame ends seen,",
             n_recv, n_phases, n_frames);
    $display("with empty clips, saturated sizes, mid-frame changes and one long output stall");
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/omb_pkg.sv
design/omb_if.sv
design/omb_front.sv
design/omb_queue.sv
design/omb_back.sv
design/one_bit_mask_or_merge_top.sv
design/omb_checker.sv
tb/tb.sv
